/* src/mau_pkg.sv */
// Package for the modular arithmetic unit: widths, command codes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
package mau_pkg;

    localparam int MOD_W  = 31;
    localparam int DATA_W = 64;
    localparam int CNT_W  = 7;
    localparam int COEF_W = MOD_W + 2;

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(998244353);
    localparam logic             REG_MODULUS = 1'b0;

    typedef enum logic [2:0] {
        CMD_REDUCE, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POW, CMD_NEG, CMD_INV
    } t_cmd;

    typedef enum logic [1:0] {FS_A, FS_B, FS_U} t_fold_sel;

    typedef enum logic [1:0] {MM_AB, MM_RX, MM_XX} t_mm_sel;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_FOLD_START, OP_FOLD_END, OP_SIMPLE, OP_MM_MUL,
        OP_MM_START, OP_MM_END, OP_PW_INIT, OP_EU_INIT, OP_EU_START, OP_EU_MUL,
        OP_EU_UPD, OP_EU_END, OP_OUT
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE, S_FOLD_GO, S_FOLD_RUN, S_FOLD_END, S_DISPATCH, S_MM_MUL, S_MM_GO,
        S_MM_RUN, S_MM_END, S_PW_CHECK, S_EU_CHECK, S_EU_GO, S_EU_RUN, S_EU_MUL,
        S_EU_UPD, S_EU_END, S_FINISH
    } t_state;

    typedef struct packed {
        t_dp_op    op;
        t_fold_sel fold_sel;
        t_mm_sel   mm_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic div_busy;
        logic n_zero;
        logic n_bit0;
        logic n_neg;
        logic eb_zero;
        logic out_free;
    } t_dp_status;

endpackage

/* src/modular_arithmetic_unit.sv */
// Modular arithmetic unit with a run-time modulus held in an APB register.
// Input channel: i_in_valid/o_in_ready carry command, operand_a, operand_b.
// Output channel: o_out_valid/i_out_ready carry result and not_invertible.
// One item is worked on at a time; every item gives exactly one result.
// Run time is set by the serial divider, which does every reduction:
//   reduce/add/sub/negate: two operand folds.
//   mul: the folds plus one product reduction.
//   pow: the folds, then one squaring per exponent bit up to the top set bit and one multiply per set bit.
//   inverse: the folds, one division per Euclid step, then a fold of the coefficient.
//   div: the inverse work plus one product reduction.
// A finished result sits in an output register; the next item is accepted
// while it waits, and the unit stalls at the end of that item only if the
// earlier result is still not taken.
// Reset clears the control state and loads the modulus with 998244353.
// Write the modulus at byte address 0 only while the unit is idle.
// A modulus of zero acts as a modulus of one.
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_command,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [MOD_W-1:0]  o_result,
    output logic              o_not_invertible,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [MOD_W-1:0] r_modulus;
    t_dp_cmd          w_cmd;
    t_dp_status       w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_MODULUS) begin
            r_modulus <= pwdata[MOD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODULUS) ? 32'(r_modulus) : '0;

    mau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mau_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_modulus        (r_modulus),
        .i_command        (i_command),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .i_out_ready      (i_out_ready),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_result         (o_result),
        .o_not_invertible (o_not_invertible)
    );

endmodule

/* src/mau_divider.sv */
// Serial restoring divider: 64-bit dividend by a MOD_W-bit divisor, one bit per cycle.
// Depends on mau_pkg.
module mau_divider
    import mau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [MOD_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [DATA_W-1:0] o_quotient,
    output logic [MOD_W-1:0]  o_remainder
);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_dq, n_dq;
    logic [MOD_W-1:0]  r_rem, n_rem;
    logic [MOD_W-1:0]  r_div;
    logic [MOD_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_dq[DATA_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_comb begin
        n_cnt = r_cnt;
        n_dq  = r_dq;
        n_rem = r_rem;
        if (i_start) begin
            n_cnt = CNT_W'(DATA_W);
            n_dq  = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_dq  = {r_dq[DATA_W-2:0], w_ge};
            n_rem = w_ge ? MOD_W'(w_trial - {1'b0, r_div}) : w_trial[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_dq  <= n_dq;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_busy      = r_cnt != '0;
    assign o_quotient  = r_dq;
    assign o_remainder = r_rem;

endmodule

/* src/mau_datapath.sv */
// Datapath of the modular arithmetic unit: operand registers, multipliers,
// Euclid coefficients and the output register. Depends on mau_pkg, mau_divider.
module mau_datapath
    import mau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [MOD_W-1:0]  i_modulus,
    input  logic [2:0]        i_command,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    input  logic              i_out_ready,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    output logic [MOD_W-1:0]  o_result,
    output logic              o_not_invertible
);

    t_cmd                     r_cmd;
    logic [DATA_W-1:0]        r_ina, r_inb, r_n;
    logic [MOD_W-1:0]         r_m, r_a, r_b, r_res, r_x, r_ea, r_eb;
    logic [2*MOD_W-1:0]       r_prod;
    logic signed [COEF_W-1:0] r_u, r_y, r_ty;
    logic                     r_fneg, r_bad;
    logic                     r_ovalid, r_obad;
    logic [MOD_W-1:0]         r_ores;

    logic              w_start;
    logic [DATA_W-1:0] w_dividend, w_fval, w_mag;
    logic [MOD_W-1:0]  w_divisor, w_rem, w_folded, w_simple, w_op1, w_op2;
    logic [DATA_W-1:0] w_quo;
    logic              w_busy;
    logic [MOD_W:0]    w_sum;
    logic signed [2*COEF_W-1:0] w_ty;

    always_comb begin
        case (i_cmd.fold_sel)
            FS_A:    w_fval = r_ina;
            FS_B:    w_fval = r_inb;
            default: w_fval = {{(DATA_W-COEF_W){r_u[COEF_W-1]}}, r_u};
        endcase
        w_mag = w_fval[DATA_W-1] ? DATA_W'(0) - w_fval : w_fval;
    end

    always_comb begin
        w_start    = 1'b0;
        w_dividend = w_mag;
        w_divisor  = r_m;
        case (i_cmd.op)
            OP_FOLD_START: w_start = 1'b1;
            OP_MM_START: begin
                w_start    = 1'b1;
                w_dividend = DATA_W'(r_prod);
            end
            OP_EU_START: begin
                w_start    = 1'b1;
                w_dividend = DATA_W'(r_ea);
                w_divisor  = r_eb;
            end
            default: w_start = 1'b0;
        endcase
    end

    mau_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_busy      (w_busy),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign w_folded = (r_fneg && w_rem != '0) ? r_m - w_rem : w_rem;

    always_comb begin
        w_sum = '0;
        case (r_cmd)
            CMD_ADD: begin
                w_sum = {1'b0, r_a} + {1'b0, r_b};
                w_simple = (w_sum >= {1'b0, r_m}) ? MOD_W'(w_sum - {1'b0, r_m})
                                                  : w_sum[MOD_W-1:0];
            end
            CMD_SUB: begin
                w_sum = {1'b0, r_a} + {1'b0, r_m} - {1'b0, r_b};
                w_simple = (w_sum >= {1'b0, r_m}) ? MOD_W'(w_sum - {1'b0, r_m})
                                                  : w_sum[MOD_W-1:0];
            end
            CMD_NEG: w_simple = (r_a != '0) ? r_m - r_a : '0;
            default: w_simple = r_a;
        endcase
    end

    always_comb begin
        case (i_cmd.mm_sel)
            MM_AB: begin
                w_op1 = r_a;
                w_op2 = r_b;
            end
            MM_RX: begin
                w_op1 = r_res;
                w_op2 = r_x;
            end
            default: begin
                w_op1 = r_x;
                w_op2 = r_x;
            end
        endcase
    end

    assign w_ty = $signed({{(COEF_W-MOD_W){1'b0}}, w_quo[MOD_W-1:0]}) * r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_cmd <= t_cmd'(i_command);
                r_ina <= i_operand_a;
                r_inb <= i_operand_b;
                r_m   <= (i_modulus == '0) ? MOD_W'(1) : i_modulus;
                r_bad <= 1'b0;
            end
            OP_FOLD_START: r_fneg <= w_fval[DATA_W-1];
            OP_FOLD_END: begin
                case (i_cmd.fold_sel)
                    FS_A: r_a <= w_folded;
                    FS_B: r_b <= w_folded;
                    default: begin
                        r_b   <= w_folded;
                        r_res <= w_folded;
                    end
                endcase
            end
            OP_SIMPLE: r_res <= w_simple;
            OP_MM_MUL: r_prod <= w_op1 * w_op2;
            OP_MM_END: begin
                if (i_cmd.mm_sel == MM_XX) begin
                    r_x <= w_rem;
                    r_n <= r_n >> 1;
                end else begin
                    r_res <= w_rem;
                end
            end
            OP_PW_INIT: begin
                r_res <= (r_m == MOD_W'(1)) ? '0 : MOD_W'(1);
                r_x   <= r_a;
                r_n   <= r_inb;
            end
            OP_EU_INIT: begin
                r_ea <= (r_cmd == CMD_DIV) ? r_b : r_a;
                r_eb <= r_m;
                r_u  <= COEF_W'(1);
                r_y  <= '0;
            end
            OP_EU_MUL: r_ty <= COEF_W'(w_ty);
            OP_EU_UPD: begin
                r_ea <= r_eb;
                r_eb <= w_rem;
                r_u  <= r_y;
                r_y  <= r_u - r_ty;
            end
            OP_EU_END: r_bad <= r_ea != MOD_W'(1);
            OP_OUT: begin
                r_ores <= r_res;
                r_obad <= r_bad;
            end
            default: begin
            end
        endcase
    end

    assign o_status.cmd      = r_cmd;
    assign o_status.div_busy = w_busy;
    assign o_status.n_zero   = r_n == '0;
    assign o_status.n_bit0   = r_n[0];
    assign o_status.n_neg    = r_n[DATA_W-1];
    assign o_status.eb_zero  = r_eb == '0;
    assign o_status.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid      = r_ovalid;
    assign o_result         = r_ores;
    assign o_not_invertible = r_obad;

endmodule

/* src/mau_ctrl.sv */
// Controller state machine of the modular arithmetic unit.
// Depends on mau_pkg.
module mau_ctrl
    import mau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state    r_state, n_state;
    t_fold_sel r_fold_sel, n_fold_sel;
    t_mm_sel   r_mm_sel, n_mm_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fold_sel <= FS_A;
            r_mm_sel   <= MM_AB;
        end else begin
            r_state    <= n_state;
            r_fold_sel <= n_fold_sel;
            r_mm_sel   <= n_mm_sel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fold_sel = r_fold_sel;
        n_mm_sel   = r_mm_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state    = S_FOLD_GO;
                    n_fold_sel = FS_A;
                end
            end
            S_FOLD_GO:  n_state = S_FOLD_RUN;
            S_FOLD_RUN: if (!i_status.div_busy) n_state = S_FOLD_END;
            S_FOLD_END: begin
                case (r_fold_sel)
                    FS_A: begin
                        n_fold_sel = FS_B;
                        n_state    = S_FOLD_GO;
                    end
                    FS_B: n_state = S_DISPATCH;
                    default: begin
                        if (i_status.cmd == CMD_DIV) begin
                            n_mm_sel = MM_AB;
                            n_state  = S_MM_MUL;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                endcase
            end
            S_DISPATCH: begin
                case (i_status.cmd) inside
                    CMD_MUL: begin
                        n_mm_sel = MM_AB;
                        n_state  = S_MM_MUL;
                    end
                    CMD_DIV, CMD_INV: n_state = S_EU_CHECK;
                    CMD_POW:          n_state = S_PW_CHECK;
                    default:          n_state = S_FINISH;
                endcase
            end
            S_MM_MUL: n_state = S_MM_GO;
            S_MM_GO:  n_state = S_MM_RUN;
            S_MM_RUN: if (!i_status.div_busy) n_state = S_MM_END;
            S_MM_END: begin
                case (r_mm_sel)
                    MM_AB: n_state = S_FINISH;
                    MM_RX: begin
                        n_mm_sel = MM_XX;
                        n_state  = S_MM_MUL;
                    end
                    default: n_state = S_PW_CHECK;
                endcase
            end
            S_PW_CHECK: begin
                if (i_status.n_neg || i_status.n_zero) begin
                    n_state = S_FINISH;
                end else begin
                    n_mm_sel = i_status.n_bit0 ? MM_RX : MM_XX;
                    n_state  = S_MM_MUL;
                end
            end
            S_EU_CHECK: n_state = i_status.eb_zero ? S_EU_END : S_EU_GO;
            S_EU_GO:    n_state = S_EU_RUN;
            S_EU_RUN:   if (!i_status.div_busy) n_state = S_EU_MUL;
            S_EU_MUL:   n_state = S_EU_UPD;
            S_EU_UPD:   n_state = S_EU_CHECK;
            S_EU_END: begin
                n_fold_sel = FS_U;
                n_state    = S_FOLD_GO;
            end
            S_FINISH: if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.fold_sel = r_fold_sel;
        o_cmd.mm_sel   = r_mm_sel;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_FOLD_GO:  o_cmd.op = OP_FOLD_START;
            S_FOLD_END: o_cmd.op = OP_FOLD_END;
            S_DISPATCH: begin
                case (i_status.cmd) inside
                    CMD_MUL:          o_cmd.op = OP_NONE;
                    CMD_DIV, CMD_INV: o_cmd.op = OP_EU_INIT;
                    CMD_POW:          o_cmd.op = OP_PW_INIT;
                    default:          o_cmd.op = OP_SIMPLE;
                endcase
            end
            S_MM_MUL: o_cmd.op = OP_MM_MUL;
            S_MM_GO:  o_cmd.op = OP_MM_START;
            S_MM_END: o_cmd.op = OP_MM_END;
            S_EU_GO:  o_cmd.op = OP_EU_START;
            S_EU_MUL: o_cmd.op = OP_EU_MUL;
            S_EU_UPD: o_cmd.op = OP_EU_UPD;
            S_EU_END: o_cmd.op = OP_EU_END;
            S_FINISH: if (i_status.out_free) o_cmd.op = OP_OUT;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

endmodule
